>>> src/modbus_rtu_write_register_master_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU write-register master
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_WRITE_REGISTER_MASTER_ASSERT_SVH
`define MODBUS_RTU_WRITE_REGISTER_MASTER_ASSERT_SVH

// same-cycle implication
`define MRWR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRWR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/mrwr_pkg.sv
// ----------------------------------------------------------------------------
// mrwr_pkg
// Types and constants for the Modbus RTU write-register (function 06) master.
// ----------------------------------------------------------------------------
`default_nettype none

package mrwr_pkg;

	// input item actions
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// transaction status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_EXCEPTION = 2'd1;
	localparam logic [1:0] STS_BAD       = 2'd2;
	localparam logic [1:0] STS_NO_REPLY  = 2'd3;

	// result kinds
	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// register indexes (paddr[2])
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_GAP     = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [7:0]  GAP_RESET     = 8'd50;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  FUNC_WRITE = 8'h06;
	localparam logic [7:0]  EXC_FLAG   = 8'h80;
	localparam logic [3:0]  FRAME_LEN  = 4'd8;
	localparam logic [3:0]  EXC_LEN    = 4'd5;
	localparam logic [3:0]  CRC_LEN    = 4'd6;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  station_addr;
		logic [15:0] holding_reg;
		logic [15:0] write_value;
		logic [7:0]  rx_data;
		logic        line_error;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [1:0]  status;
		logic [7:0]  exception_code;
		logic [3:0]  received_count;
	} result_t;

	// one shift step of the reflected CRC-16/MODBUS
	function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
		crc_bit_step = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
	endfunction

endpackage

`default_nettype wire

>>> src/modbus_rtu_write_register_master.sv
// ----------------------------------------------------------------------------
// modbus_rtu_write_register_master
// Modbus RTU master for function 06 (write single holding register).
// ----------------------------------------------------------------------------
// A start item builds the 8-byte request and returns it as eight transmit
// results (last set on the final CRC byte), then the block collects reply
// bytes, counts 100 us ticks for the response timeout and inter-frame gap, and
// returns one status result. A start runs its 48 bits through the shared CRC
// shifter at one bit per cycle, then hands the bytes to the output register,
// which waits while the result side stalls. A reply byte among the first six
// then takes 8 CRC bit steps; later bytes and ticks finish on acceptance, but
// one that ends the transaction then goes through the status verdict step.
// Not ready while the CRC shifter or the transmit and verdict steps are
// running.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_write_register_master (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_ready,
	input  wire mrwr_pkg::item_t   item,
	output logic                   result_valid,
	input  wire                    result_ready,
	output mrwr_pkg::result_t      result,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [2:0]             paddr,
	input  wire  [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CRC   = 3'd1;
	localparam logic [2:0] ST_TX    = 3'd2;
	localparam logic [2:0] ST_RXCRC = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]  state_q;
	logic [15:0] timeout_cfg_q;
	logic [7:0]  gap_cfg_q;

	logic        busy_q;
	logic [7:0]  target_q;
	logic [15:0] addr_q;
	logic [15:0] value_q;
	logic [7:0]  rx_byte_q;
	logic [7:0]  reply_bytes_q [8];
	logic [3:0]  reply_count_q;
	logic [15:0] crc_q;
	logic [15:0] timeout_q;
	logic [7:0]  gap_q;
	logic        byte_seen_q;
	logic [2:0]  byte_idx_q;
	logic [2:0]  bit_idx_q;

	logic              result_valid_q;
	mrwr_pkg::result_t result_q;

	logic        out_free;
	logic        out_load;
	logic [7:0]  msg_byte;
	logic [7:0]  unit_byte;
	logic [15:0] crc_in;
	logic [15:0] crc_next;
	logic        tick_done;
	logic        is_exception;
	logic        is_success;
	logic [1:0]  verdict;

	assign pready       = 1'b1;
	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;
	assign out_load     = ((state_q == ST_TX) || (state_q == ST_FIN)) && out_free;

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == mrwr_pkg::REG_GAP) begin
			prdata[7:0] = gap_cfg_q;
		end else begin
			prdata[15:0] = timeout_cfg_q;
		end
	end

	always_comb begin
		case (byte_idx_q)
			3'd0:    msg_byte = target_q;
			3'd1:    msg_byte = mrwr_pkg::FUNC_WRITE;
			3'd2:    msg_byte = addr_q[15:8];
			3'd3:    msg_byte = addr_q[7:0];
			3'd4:    msg_byte = value_q[15:8];
			3'd5:    msg_byte = value_q[7:0];
			3'd6:    msg_byte = crc_q[7:0];
			3'd7:    msg_byte = crc_q[15:8];
			default: msg_byte = 8'd0;
		endcase
	end

	// shared CRC shifter: the byte is folded in on the first bit step
	assign unit_byte = (state_q == ST_CRC) ? msg_byte : rx_byte_q;
	assign crc_in    = crc_q ^ {8'd0, (bit_idx_q == 3'd0) ? unit_byte : 8'd0};
	assign crc_next  = mrwr_pkg::crc_bit_step(crc_in);

	// a line error on a tick wipes byte_seen before the gap check
	assign tick_done = (timeout_q <= 16'd1) ||
		(byte_seen_q && !item.line_error && gap_q <= 8'd1);

	assign is_exception = (reply_count_q == mrwr_pkg::EXC_LEN) &&
		(reply_bytes_q[0] == target_q) &&
		((reply_bytes_q[1] & mrwr_pkg::EXC_FLAG) != 8'd0);
	assign is_success = (reply_count_q == mrwr_pkg::FRAME_LEN) &&
		(reply_bytes_q[0] == target_q) &&
		(reply_bytes_q[1] == mrwr_pkg::FUNC_WRITE) &&
		(reply_bytes_q[6] == crc_q[7:0]) &&
		(reply_bytes_q[7] == crc_q[15:8]);

	always_comb begin
		if (is_exception) begin
			verdict = mrwr_pkg::STS_EXCEPTION;
		end else if (is_success) begin
			verdict = mrwr_pkg::STS_OK;
		end else if (reply_count_q == 4'd0) begin
			verdict = mrwr_pkg::STS_NO_REPLY;
		end else begin
			verdict = mrwr_pkg::STS_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			timeout_cfg_q  <= mrwr_pkg::TIMEOUT_RESET;
			gap_cfg_q      <= mrwr_pkg::GAP_RESET;
			busy_q         <= 1'b0;
			target_q       <= 8'd0;
			reply_count_q  <= 4'd0;
			crc_q          <= mrwr_pkg::CRC_INIT;
			timeout_q      <= 16'd0;
			gap_q          <= 8'd0;
			byte_seen_q    <= 1'b0;
			byte_idx_q     <= 3'd0;
			bit_idx_q      <= 3'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == mrwr_pkg::REG_GAP) begin
					gap_cfg_q <= pwdata[7:0];
				end else begin
					timeout_cfg_q <= pwdata[15:0];
				end
			end

			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.action)
							mrwr_pkg::ACT_START: begin
								if (!busy_q) begin
									target_q   <= item.station_addr;
									addr_q     <= item.holding_reg;
									value_q    <= item.write_value;
									crc_q      <= mrwr_pkg::CRC_INIT;
									byte_idx_q <= 3'd0;
									bit_idx_q  <= 3'd0;
									state_q    <= ST_CRC;
								end
							end
							mrwr_pkg::ACT_BYTE: begin
								if (busy_q) begin
									if (item.line_error) begin
										reply_count_q <= 4'd0;
										crc_q         <= mrwr_pkg::CRC_INIT;
										byte_seen_q   <= 1'b0;
										gap_q         <= 8'd0;
									end else begin
										reply_bytes_q[reply_count_q[2:0]] <= item.rx_data;
										rx_byte_q     <= item.rx_data;
										reply_count_q <= reply_count_q + 4'd1;
										byte_seen_q   <= 1'b1;
										gap_q         <= gap_cfg_q;
										if (reply_count_q < mrwr_pkg::CRC_LEN) begin
											bit_idx_q <= 3'd0;
											state_q   <= ST_RXCRC;
										end else if (reply_count_q == mrwr_pkg::FRAME_LEN - 4'd1) begin
											state_q <= ST_FIN;
										end
									end
								end
							end
							mrwr_pkg::ACT_TICK: begin
								if (busy_q) begin
									if (item.line_error) begin
										reply_count_q <= 4'd0;
										crc_q         <= mrwr_pkg::CRC_INIT;
										byte_seen_q   <= 1'b0;
										gap_q         <= 8'd0;
									end else if (byte_seen_q && gap_q > 8'd1) begin
										gap_q <= gap_q - 8'd1;
									end
									if (timeout_q <= 16'd1) begin
										timeout_q <= 16'd0;
									end else begin
										timeout_q <= timeout_q - 16'd1;
									end
									if (tick_done) begin
										state_q <= ST_FIN;
									end
								end
							end
							default: ;
						endcase
					end
				end

				ST_CRC: begin
					crc_q     <= crc_next;
					bit_idx_q <= bit_idx_q + 3'd1;
					if (bit_idx_q == 3'd7) begin
						if (byte_idx_q == 3'd5) begin
							byte_idx_q <= 3'd0;
							state_q    <= ST_TX;
						end else begin
							byte_idx_q <= byte_idx_q + 3'd1;
						end
					end
				end

				ST_TX: begin
					if (out_free) begin
						result_q.kind           <= mrwr_pkg::KIND_TX;
						result_q.tx_byte        <= msg_byte;
						result_q.last           <= (byte_idx_q == 3'd7);
						result_q.status         <= mrwr_pkg::STS_OK;
						result_q.exception_code <= 8'd0;
						result_q.received_count <= 4'd0;
						byte_idx_q              <= byte_idx_q + 3'd1;
						if (byte_idx_q == 3'd7) begin
							busy_q        <= 1'b1;
							timeout_q     <= timeout_cfg_q;
							reply_count_q <= 4'd0;
							crc_q         <= mrwr_pkg::CRC_INIT;
							byte_seen_q   <= 1'b0;
							gap_q         <= 8'd0;
							state_q       <= ST_IDLE;
						end
					end
				end

				ST_RXCRC: begin
					crc_q     <= crc_next;
					bit_idx_q <= bit_idx_q + 3'd1;
					if (bit_idx_q == 3'd7) begin
						state_q <= ST_IDLE;
					end
				end

				ST_FIN: begin
					if (out_free) begin
						result_q.kind           <= mrwr_pkg::KIND_STATUS;
						result_q.tx_byte        <= 8'd0;
						result_q.last           <= 1'b0;
						result_q.status         <= verdict;
						result_q.exception_code <= is_exception ? reply_bytes_q[2] : 8'd0;
						result_q.received_count <= reply_count_q;
						busy_q                  <= 1'b0;
						state_q                 <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/mrwr_checker.sv
// ----------------------------------------------------------------------------
// mrwr_checker
// Port-level checks for the Modbus RTU write-register master, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_write_register_master_assert.svh"

module mrwr_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    result_valid,
	input wire                    result_ready,
	input wire mrwr_pkg::result_t result
);

	logic is_status;

	assign is_status = result_valid && (result.kind == mrwr_pkg::KIND_STATUS);

	`MRWR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

	`MRWR_ASSERT_IMPL(a_tx_clean, result_valid && (result.kind == mrwr_pkg::KIND_TX), (result.status == mrwr_pkg::STS_OK) && (result.received_count == 4'd0), "transmit byte carries status fields")

	`MRWR_ASSERT_IMPL(a_no_reply_count, is_status, (result.status == mrwr_pkg::STS_NO_REPLY) == (result.received_count == 4'd0), "no-reply status disagrees with byte count")

	`MRWR_ASSERT_IMPL(a_success_len, is_status && (result.status == mrwr_pkg::STS_OK), result.received_count == mrwr_pkg::FRAME_LEN, "success without a full frame")

	`MRWR_ASSERT_IMPL(a_exc_code, is_status && (result.status != mrwr_pkg::STS_EXCEPTION), result.exception_code == 8'd0, "exception code outside exception status")

endmodule

bind modbus_rtu_write_register_master mrwr_checker u_mrwr_checker (.*);

`default_nettype wire

>>> bench/modbus_rtu_write_register_master_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_write_register_master_checker
// Watches the item, result and register ports of the function 06 master and
// keeps its own model of the request builder and reply collector. Every
// transmit byte and status it predicts is queued and compared field by field
// with the results the block hands out. Mismatches are counted for the test.
// ----------------------------------------------------------------------------

module modbus_rtu_write_register_master_checker (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	input  wire                    item_ready,
	input  mrwr_pkg::item_t        item,
	input  wire                    result_valid,
	input  wire                    result_ready,
	input  mrwr_pkg::result_t      result,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [2:0]             paddr,
	input  wire  [31:0]            pwdata,
	input  wire                    pready,
	output int                     mismatches,
	output int                     results_owed,
	output logic                   exchange_open,
	output logic [63:0]            last_request
);

	logic [15:0] timeout_cfg;
	logic [7:0]  gap_cfg;

	logic [7:0]  slave_sel;
	logic [7:0]  reply_buf [8];
	logic [3:0]  reply_cnt;
	logic [15:0] reply_crc;
	logic [15:0] ticks_left;
	logic [7:0]  gap_left;
	logic        heard;

	mrwr_pkg::result_t owed_q [$];

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ mrwr_pkg::CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic owe(input logic kind, input logic [7:0] txb, input logic lst,
			input logic [1:0] st, input logic [7:0] exc, input logic [3:0] cnt);
		mrwr_pkg::result_t r;
		r.kind = kind;
		r.tx_byte = txb;
		r.last = lst;
		r.status = st;
		r.exception_code = exc;
		r.received_count = cnt;
		owed_q.push_back(r);
	endtask

	task automatic clear_collection();
		reply_cnt = '0;
		reply_crc = mrwr_pkg::CRC_INIT;
		heard = 1'b0;
		gap_left = '0;
	endtask

	task automatic close_exchange();
		logic [1:0] st;
		logic [7:0] exc;
		exc = 8'h00;
		if (reply_cnt == mrwr_pkg::EXC_LEN && reply_buf[0] == slave_sel
				&& (reply_buf[1] & mrwr_pkg::EXC_FLAG) != 8'h00) begin
			st = mrwr_pkg::STS_EXCEPTION;
			exc = reply_buf[2];
		end else if (reply_cnt == mrwr_pkg::FRAME_LEN) begin
			st = (reply_buf[0] == slave_sel && reply_buf[1] == mrwr_pkg::FUNC_WRITE
				&& reply_buf[6] == reply_crc[7:0] && reply_buf[7] == reply_crc[15:8])
				? mrwr_pkg::STS_OK : mrwr_pkg::STS_BAD;
		end else if (reply_cnt == 4'd0) begin
			st = mrwr_pkg::STS_NO_REPLY;
		end else begin
			st = mrwr_pkg::STS_BAD;
		end
		owe(mrwr_pkg::KIND_STATUS, '0, 1'b0, st, exc, reply_cnt);
		exchange_open = 1'b0;
	endtask

	task automatic take_item(input mrwr_pkg::item_t it);
		logic [47:0] body;
		logic [15:0] crc;
		logic        done;
		case (it.action)
			mrwr_pkg::ACT_START: begin
				// a start during an open exchange is dropped
				if (!exchange_open) begin
					slave_sel = it.station_addr;
					body = {it.station_addr, mrwr_pkg::FUNC_WRITE, it.holding_reg,
						it.write_value};
					crc = mrwr_pkg::CRC_INIT;
					for (int i = 0; i < 6; i++)
						crc = crc16_byte(crc, body[47 - 8 * i -: 8]);
					last_request = {body, crc[7:0], crc[15:8]};
					for (int i = 0; i < 8; i++)
						owe(mrwr_pkg::KIND_TX, last_request[63 - 8 * i -: 8], i == 7,
							'0, '0, '0);
					exchange_open = 1'b1;
					ticks_left = timeout_cfg;
					clear_collection();
				end
			end
			mrwr_pkg::ACT_BYTE: begin
				if (exchange_open) begin
					if (it.line_error) begin
						clear_collection();
					end else begin
						if (reply_cnt < mrwr_pkg::FRAME_LEN) begin
							reply_buf[reply_cnt[2:0]] = it.rx_data;
							if (reply_cnt < mrwr_pkg::CRC_LEN)
								reply_crc = crc16_byte(reply_crc, it.rx_data);
							reply_cnt = reply_cnt + 4'd1;
						end
						heard = 1'b1;
						gap_left = gap_cfg;
						if (reply_cnt >= mrwr_pkg::FRAME_LEN)
							close_exchange();
					end
				end
			end
			mrwr_pkg::ACT_TICK: begin
				if (exchange_open) begin
					done = 1'b0;
					// the tick still runs the timeout after a line error
					if (it.line_error)
						clear_collection();
					if (ticks_left <= 16'd1) begin
						ticks_left = '0;
						done = 1'b1;
					end else begin
						ticks_left = ticks_left - 16'd1;
					end
					if (heard) begin
						if (gap_left <= 8'd1)
							done = 1'b1;
						else
							gap_left = gap_left - 8'd1;
					end
					if (done)
						close_exchange();
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input mrwr_pkg::result_t got);
		mrwr_pkg::result_t want;
		if (owed_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: kind %0d tx %02h last %0d status %0d exc %02h count %0d",
					got.kind, got.tx_byte, got.last, got.status, got.exception_code,
					got.received_count);
		end else begin
			want = owed_q.pop_front();
			if (got.kind !== want.kind || got.tx_byte !== want.tx_byte
					|| got.last !== want.last || got.status !== want.status
					|| got.exception_code !== want.exception_code
					|| got.received_count !== want.received_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected kind %0d tx %02h last %0d status %0d exc %02h ",
						want.kind, want.tx_byte, want.last, want.status, want.exception_code,
						"count %0d, got kind %0d tx %02h last %0d status %0d exc %02h count %0d",
						want.received_count, got.kind, got.tx_byte, got.last, got.status,
						got.exception_code, got.received_count);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_cfg = mrwr_pkg::TIMEOUT_RESET;
			gap_cfg = mrwr_pkg::GAP_RESET;
			exchange_open = 1'b0;
			slave_sel = '0;
			for (int i = 0; i < 8; i++)
				reply_buf[i] = '0;
			ticks_left = '0;
			clear_collection();
			last_request = '0;
			owed_q.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					mrwr_pkg::REG_TIMEOUT: timeout_cfg = pwdata[15:0];
					mrwr_pkg::REG_GAP:     gap_cfg = pwdata[7:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready)
				check_result(result);
			if (item_valid && item_ready)
				take_item(item);
		end
		results_owed = owed_q.size();
	end

endmodule

>>> bench/modbus_rtu_write_register_master_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_write_register_master_test
// Drives the function 06 master with starts, reply bytes and ticks: a short
// directed run, then random exchanges (clean echoes, exceptions, corrupted and
// short replies, silence, line errors) under several timeout and gap settings,
// with random stalls on both channels. The checker scores every result.
// ----------------------------------------------------------------------------

module modbus_rtu_write_register_master_test;

	localparam int SETTLE_CYCLES = 100;   // quiet time after every owed result is out
	localparam int LONG_HOLD = 600;
	localparam int WATCHDOG_CYCLES = 5000;
	localparam int PHASE_ITEMS = 55;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	mrwr_pkg::item_t   item;
	logic              result_valid;
	logic              result_ready;
	mrwr_pkg::result_t result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int          mismatches;
	int          results_owed;
	logic        exchange_open;
	logic [63:0] last_request;

	int          items_sent;
	int          quiet_cycles;
	logic        calm;
	logic        hold_req;
	logic [7:0]  gap_now;

	modbus_rtu_write_register_master dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	modbus_rtu_write_register_master_checker mirror (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.results_owed  (results_owed),
		.exchange_open (exchange_open),
		.last_request  (last_request)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic mrwr_pkg::item_t rand_item(input logic [1:0] act, input logic lerr);
		logic [63:0] bits;
		mrwr_pkg::item_t it;
		bits = {$urandom, $urandom};
		it = bits[$bits(mrwr_pkg::item_t) - 1:0];
		it.action = act;
		it.line_error = lerr;
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer(input mrwr_pkg::item_t it);
		int g;
		g = pick_gap();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_start(input logic [7:0] sl, input logic [15:0] ad, input logic [15:0] val);
		mrwr_pkg::item_t it;
		it = rand_item(mrwr_pkg::ACT_START, 1'($urandom_range(0, 1)));
		it.station_addr = sl;
		it.holding_reg = ad;
		it.write_value = val;
		offer(it);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lerr);
		mrwr_pkg::item_t it;
		it = rand_item(mrwr_pkg::ACT_BYTE, lerr);
		it.rx_data = b;
		offer(it);
	endtask

	task automatic send_tick(input logic lerr);
		offer(rand_item(mrwr_pkg::ACT_TICK, lerr));
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(input logic [15:0] t, input logic [7:0] g);
		apb_write(mrwr_pkg::REG_TIMEOUT, {16'h0000, t});
		apb_write(mrwr_pkg::REG_GAP, {24'h000000, g});
		gap_now = g;
	endtask

	// stop offering until every owed result is out, then let the block go quiet
	task automatic settle();
		item_valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic exchange();
		logic [7:0] reply [8];
		logic [7:0] sl;
		logic       noisy;
		int         n;
		int         shape;
		int         k;
		int         limit;
		int         j;
		case ($urandom_range(0, 5))
			0:       sl = 8'h00;
			1:       sl = 8'hFF;
			default: sl = 8'($urandom_range(0, 255));
		endcase
		send_start(sl, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		if ($urandom_range(0, 9) == 0)
			send_start(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
		// a correct reply to function 06 echoes the request
		for (int i = 0; i < 8; i++)
			reply[i] = last_request[63 - 8 * i -: 8];
		n = 8;
		shape = $urandom_range(0, 9);
		case (shape)
			3: begin
				k = $urandom_range(0, 7);
				reply[k] = reply[k] ^ (8'h01 << $urandom_range(0, 7));
			end
			4, 5: begin
				n = 5;
				reply[1] = mrwr_pkg::FUNC_WRITE | mrwr_pkg::EXC_FLAG;
				for (int i = 2; i < 5; i++)
					reply[i] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 4) == 0)
					reply[0] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 4) == 0)
					reply[1] = 8'($urandom_range(0, 255));
			end
			6: begin
				n = $urandom_range(1, 7);
				for (int i = 1; i < 8; i++)
					reply[i] = 8'($urandom_range(0, 255));
			end
			7: n = 0;
			8: begin
				reply[0] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 1) == 0)
					reply[1] = 8'($urandom_range(0, 255));
			end
			default: ;
		endcase
		noisy = (shape == 9);
		for (int i = 0; i < n && exchange_open; i++) begin
			send_byte(reply[i], noisy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 49) == 0));
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, (gap_now > 10) ? 10 : gap_now + 1);
				for (j = 0; j < k && exchange_open; j++)
					send_tick($urandom_range(0, 29) == 0);
			end
		end
		// let the gap or the timeout close the exchange, else fill the frame
		limit = (n == 0) ? 40 : ((gap_now > 16) ? 16 : gap_now + 3);
		for (j = 0; j < limit && exchange_open; j++)
			send_tick($urandom_range(0, 29) == 0);
		while (exchange_open)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		if ($urandom_range(0, 7) == 0)
			offer(rand_item(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1))));
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin : ready_driver
		int   stall_left;
		logic held;
		stall_left = 0;
		held = 1'b0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("modbus_rtu_write_register_master_test: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		mrwr_pkg::item_t it;
		int              phase_end;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		calm = 1'b0;
		items_sent = 0;
		gap_now = mrwr_pkg::GAP_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle noise, clean echo, exception, silence
		set_regs(16'd4, 8'd2);
		send_byte(8'hFF, 1'b0);
		send_tick(1'b1);
		it = '1;
		offer(it);
		send_start(8'h00, 16'h0000, 16'h0000);
		for (int i = 0; i < 8; i++)
			send_byte(last_request[63 - 8 * i -: 8], 1'b0);
		send_start(8'hFF, 16'hFFFF, 16'hFFFF);
		send_byte(8'hFF, 1'b0);
		send_byte(mrwr_pkg::FUNC_WRITE | mrwr_pkg::EXC_FLAG, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		send_start(8'h11, 16'h1234, 16'hABCD);
		repeat (4) send_tick(1'b0);
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0:       set_regs(16'd1, 8'd1);
				1:       set_regs(16'hFFFF, 8'hFF);
				2:       set_regs(16'd0, 8'd0);
				3:       set_regs(mrwr_pkg::TIMEOUT_RESET, mrwr_pkg::GAP_RESET);
				default: set_regs(16'($urandom_range(6, 40)), 8'($urandom_range(2, 6)));
			endcase
			calm = (ph == 4);
			// receiver holds off while the sender keeps going
			if (ph == 5)
				hold_req <= 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				exchange();
			settle();
		end

		if (mismatches == 0 && results_owed == 0)
			$display("modbus_rtu_write_register_master_test: done, clean");
		else
			$display("modbus_rtu_write_register_master_test: done, errors");
		$finish;
	end

endmodule

>>> modbus_rtu_write_register_master.f
+incdir+src
src/mrwr_pkg.sv
src/modbus_rtu_write_register_master.sv
src/mrwr_checker.sv
bench/modbus_rtu_write_register_master_checker.sv
bench/modbus_rtu_write_register_master_test.sv
